// File: src/nscc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence checksum checker package
// Character codes, line phase type, verdict type and the hex digit decoder
// shared by the checker modules.
// ----------------------------------------------------------------------------
package nscc_pkg;

  // Character codes that steer the line parser.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Number of hex digits read after the delimiter.
  localparam logic [1:0] HEX_DIGITS_MAX = 2'd2;

  // Width of the packed result item on the output stream.
  localparam int unsigned OUT_TDATA_W = 24;

  // Where the parser stands within the current line.
  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_BODY  = 2'd1,
    PH_HEX   = 2'd2
  } phase_e;

  // Verdict for one line.
  typedef struct packed {
    logic [7:0] received_sum;
    logic [7:0] computed_sum;
    logic       star_found;
    logic       line_valid;
  } verdict_t;

  // Decoded hex digit: ok is clear when the character is no hex digit.
  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } hex_digit_t;

  // Decode one character as a hex digit of either case.
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.ok     = 1'b0;
    r.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok     = 1'b1;
      r.nibble = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      // 'A'..'F' and 'a'..'f' share the low nibble 1..6.
      r.ok     = 1'b1;
      r.nibble = c[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

// File: src/nmea_sentence_checksum_checker_core.sv
// Input side: a byte is registered at acceptance; its verdict, if it is a line feed,
// is loaded into the output register when the byte leaves the input register.
// Throughput: one byte per cycle unless a line feed is held; the parse state update is a single XOR/shift step.
// A line feed waits in the input register only while the output register is full.
// Reset (rst_ni low, asynchronous) empties both registers and starts a fresh line.
// ----------------------------------------------------------------------------
// NMEA sentence checksum checker core
// Checks the XOR checksum of NMEA 0183 lines received one byte per item and
// emits one verdict item for each line feed.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_checker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [nscc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
  // m_axis_tdata_o: [0] line_valid, [1] star_found, [9:2] computed_sum,
  // [17:10] received_sum, [23:18] zero
);

  logic               in_valid_q, in_valid_d;
  logic [7:0]         in_byte_q;
  logic               in_lf;
  logic               advance;
  logic               out_free;
  nscc_pkg::verdict_t verdict;
  nscc_pkg::verdict_t out_verdict;

  // A held byte moves on unless it is a line feed facing a full output.
  assign in_lf           = (in_byte_q == nscc_pkg::CH_LF);
  assign advance         = in_valid_q && (!in_lf || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_valid_d      = (s_axis_tvalid_i && s_axis_tready_o) || (in_valid_q && !advance);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  nscc_line_tracker u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .data_i    (in_byte_q),
    .verdict_o (verdict)
  );

  nscc_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance && in_lf),
    .verdict_i (verdict),
    .free_o    (out_free),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .verdict_o (out_verdict)
  );

  // Pack the verdict item, padded to whole bytes.
  assign m_axis_tdata_o = {6'd0, out_verdict};

endmodule

// File: src/nscc_line_tracker.sv
// ----------------------------------------------------------------------------
// NMEA line tracker
// Holds the per-line parse state, folds in one character per step and
// presents the verdict that a line feed would produce.
// ----------------------------------------------------------------------------
module nscc_line_tracker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,     // consume data_i this cycle
  input  logic [7:0]         data_i,
  output nscc_pkg::verdict_t verdict_o   // verdict if data_i is a line feed
);

  nscc_pkg::phase_e     phase_q, phase_d;
  logic                 start_ok_q, start_ok_d;
  logic [7:0]           xor_sum_q, xor_sum_d;
  logic                 zero_seen_q, zero_seen_d;
  logic                 star_seen_q, star_seen_d;
  logic [7:0]           hex_value_q, hex_value_d;
  logic [1:0]           digits_q, digits_d;
  logic                 hex_stop_q, hex_stop_d;
  nscc_pkg::hex_digit_t digit;
  logic                 is_lf;

  assign is_lf = (data_i == nscc_pkg::CH_LF);
  assign digit = nscc_pkg::hex_decode(data_i);

  // Verdict from the state as it stands before the line feed.
  always_comb begin
    verdict_o.line_valid   = start_ok_q & star_seen_q & (xor_sum_q == hex_value_q);
    verdict_o.star_found   = star_seen_q;
    verdict_o.computed_sum = xor_sum_q;
    verdict_o.received_sum = hex_value_q;
  end

  // Next state of the parser.
  always_comb begin
    phase_d     = phase_q;
    start_ok_d  = start_ok_q;
    xor_sum_d   = xor_sum_q;
    zero_seen_d = zero_seen_q;
    star_seen_d = star_seen_q;
    hex_value_d = hex_value_q;
    digits_d    = digits_q;
    hex_stop_d  = hex_stop_q;
    if (is_lf) begin
      phase_d     = nscc_pkg::PH_FIRST;
      start_ok_d  = 1'b0;
      xor_sum_d   = 8'd0;
      zero_seen_d = 1'b0;
      star_seen_d = 1'b0;
      hex_value_d = 8'd0;
      digits_d    = 2'd0;
      hex_stop_d  = 1'b0;
    end else begin
      case (phase_q)
        nscc_pkg::PH_FIRST: begin
          start_ok_d = (data_i == nscc_pkg::CH_DOLLAR);
          phase_d    = nscc_pkg::PH_BODY;
        end
        nscc_pkg::PH_BODY: begin
          if (data_i == nscc_pkg::CH_STAR) begin
            star_seen_d = 1'b1;
            phase_d     = nscc_pkg::PH_HEX;
          end else if (!zero_seen_q) begin
            if (data_i == nscc_pkg::CH_NUL) begin
              zero_seen_d = 1'b1;
            end else begin
              xor_sum_d = xor_sum_q ^ data_i;
            end
          end
        end
        default: begin
          // After the delimiter: shift in hex digits until a non-digit or two digits.
          if (!hex_stop_q && digits_q < nscc_pkg::HEX_DIGITS_MAX) begin
            if (!digit.ok) begin
              hex_stop_d = 1'b1;
            end else begin
              hex_value_d = {hex_value_q[3:0], digit.nibble};
              digits_d    = digits_q + 2'd1;
            end
          end
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= nscc_pkg::PH_FIRST;
      start_ok_q  <= 1'b0;
      xor_sum_q   <= 8'd0;
      zero_seen_q <= 1'b0;
      star_seen_q <= 1'b0;
      hex_value_q <= 8'd0;
      digits_q    <= 2'd0;
      hex_stop_q  <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      start_ok_q  <= start_ok_d;
      xor_sum_q   <= xor_sum_d;
      zero_seen_q <= zero_seen_d;
      star_seen_q <= star_seen_d;
      hex_value_q <= hex_value_d;
      digits_q    <= digits_d;
      hex_stop_q  <= hex_stop_d;
    end
  end

`ifndef SYNTHESIS
  // A line feed leaves the parser at the start of a fresh line.
  a_lf_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && is_lf) |=> (phase_q == nscc_pkg::PH_FIRST && xor_sum_q == 8'd0 &&
                           !star_seen_q && hex_value_q == 8'd0))
    else $error("line state not cleared after line feed");

  // The delimiter flag and the after-delimiter phase go together.
  a_star_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    star_seen_q == (phase_q == nscc_pkg::PH_HEX))
    else $error("star flag disagrees with phase");

  // Digits are only taken after the delimiter, never more than two.
  a_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digits_q != 2'd0) |-> (star_seen_q && digits_q <= nscc_pkg::HEX_DIGITS_MAX))
    else $error("hex digit count out of place");
`endif

endmodule

// File: src/nscc_out_reg.sv
// ----------------------------------------------------------------------------
// NMEA verdict output register
// Holds one verdict item for the output stream and reports whether it can
// take a new one in the current cycle.
// ----------------------------------------------------------------------------
module nscc_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,     // capture verdict_i this cycle
  input  nscc_pkg::verdict_t verdict_i,
  output logic               free_o,     // a load this cycle is taken
  output logic               valid_o,
  input  logic               ready_i,
  output nscc_pkg::verdict_t verdict_o
);

  logic               valid_q, valid_d;
  nscc_pkg::verdict_t data_q;

  // The slot is free when empty or when the held item leaves now.
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= verdict_i;
    end
  end

  assign valid_o   = valid_q;
  assign verdict_o = data_q;

endmodule

// File: bench/nmea_sentence_checksum_checker_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence checksum checker core testbench
// Streams received bytes into the checker and compares every verdict item
// field by field with a software copy of the line parser. Directed lines
// cover the corner cases. Random lines, mostly well formed with correct or
// corrupted checksums, follow. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_checker_core_tb;

  localparam int unsigned RANDOM_BYTES = 500;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES  = 80;

  // Line parser kept alongside the block; it queues one verdict per line feed.
  class verdict_board;
    nscc_pkg::phase_e   phase;
    bit                 dollar_first;
    logic [7:0]         body_xor;
    bit                 nul_stop;
    bit                 star_hit;
    logic [7:0]         digit_val;
    int unsigned        digit_cnt;
    bit                 digits_done;
    nscc_pkg::verdict_t verdict_q[$];
    int unsigned        errors;
    int unsigned        verdicts_seen;
    int unsigned        valid_lines;
    int unsigned        star_lines;

    function new();
      errors        = 0;
      verdicts_seen = 0;
      valid_lines   = 0;
      star_lines    = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase        = nscc_pkg::PH_FIRST;
      dollar_first = 1'b0;
      body_xor     = 8'd0;
      nul_stop     = 1'b0;
      star_hit     = 1'b0;
      digit_val    = 8'd0;
      digit_cnt    = 0;
      digits_done  = 1'b0;
    endfunction

    // Note one accepted byte and advance the parser.
    function void note_byte(logic [7:0] c);
      nscc_pkg::verdict_t v;
      int                 nib;
      if (c == nscc_pkg::CH_LF) begin
        v.line_valid   = dollar_first && star_hit && (body_xor == digit_val);
        v.star_found   = star_hit;
        v.computed_sum = body_xor;
        v.received_sum = digit_val;
        verdict_q.push_back(v);
        clear_line();
        return;
      end
      case (phase)
        nscc_pkg::PH_FIRST: begin
          dollar_first = (c == nscc_pkg::CH_DOLLAR);
          phase        = nscc_pkg::PH_BODY;
        end
        nscc_pkg::PH_BODY: begin
          if (c == nscc_pkg::CH_STAR) begin
            star_hit = 1'b1;
            phase    = nscc_pkg::PH_HEX;
          end else if (!nul_stop) begin
            if (c == nscc_pkg::CH_NUL) nul_stop = 1'b1;
            else body_xor = body_xor ^ c;
          end
        end
        default: begin
          if (!digits_done && digit_cnt < 2) begin
            if (c >= "0" && c <= "9") nib = c - "0";
            else if (c >= "A" && c <= "F") nib = c - "A" + 10;
            else if (c >= "a" && c <= "f") nib = c - "a" + 10;
            else nib = -1;
            if (nib < 0) begin
              digits_done = 1'b1;
            end else begin
              digit_val = {digit_val[3:0], 4'(nib)};
              digit_cnt++;
            end
          end
        end
      endcase
    endfunction

    // Compare one verdict item from the output stream with the oldest one queued.
    function void check_verdict(logic [nscc_pkg::OUT_TDATA_W-1:0] word);
      nscc_pkg::verdict_t want;
      nscc_pkg::verdict_t got;
      got = nscc_pkg::verdict_t'(word[$bits(nscc_pkg::verdict_t)-1:0]);
      if (verdict_q.size() == 0) begin
        $error("verdict item with none queued: tdata=%h", word);
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      verdicts_seen++;
      if (want.line_valid) valid_lines++;
      if (want.star_found) star_lines++;
      if (got.line_valid !== want.line_valid) begin
        $error("line_valid: expected %0d, got %0d", want.line_valid, got.line_valid);
        errors++;
      end
      if (got.star_found !== want.star_found) begin
        $error("star_found: expected %0d, got %0d", want.star_found, got.star_found);
        errors++;
      end
      if (got.computed_sum !== want.computed_sum) begin
        $error("computed_sum: expected %h, got %h", want.computed_sum, got.computed_sum);
        errors++;
      end
      if (got.received_sum !== want.received_sum) begin
        $error("received_sum: expected %h, got %h", want.received_sum, got.received_sum);
        errors++;
      end
      if (word[nscc_pkg::OUT_TDATA_W-1:$bits(nscc_pkg::verdict_t)] !== '0) begin
        $error("tdata padding: expected 0, got %h",
               word[nscc_pkg::OUT_TDATA_W-1:$bits(nscc_pkg::verdict_t)]);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return verdict_q.size();
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid_i;
  logic                             s_axis_tready_o;
  logic [7:0]                       s_axis_tdata_i;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i;
  logic [nscc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;

  verdict_board board;
  int unsigned  bytes_sent;
  int unsigned  cycle_cnt;
  int unsigned  stall_left;
  int unsigned  hold_left;
  bit           hold_req;
  bit           no_idle;

  nmea_sentence_checksum_checker_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Clock.
  always #1 clk_i = ~clk_i;

  // Gap length: mostly none, some short, a few long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 10) return 8'("0") + 8'(n);
    return (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
  endfunction

  // Offer one byte and wait until it is accepted.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // One random line: mostly well-formed sentences, some broken, some noise.
  task automatic send_random_line();
    int unsigned kind;
    int unsigned len;
    logic [7:0]  sum;
    logic [7:0]  b;
    bit          stopped;
    kind    = $urandom_range(0, 9);
    no_idle = ($urandom_range(0, 3) == 0);
    sum     = 8'd0;
    stopped = 1'b0;
    if (kind <= 6) begin
      send_byte(nscc_pkg::CH_DOLLAR);
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 19))
          0:       b = nscc_pkg::CH_NUL;
          1:       b = 8'($urandom_range(128, 255));
          default: b = 8'($urandom_range(32, 126));
        endcase
        if (b == nscc_pkg::CH_STAR) b = "A";
        if (b == nscc_pkg::CH_NUL) stopped = 1'b1;
        else if (!stopped) sum ^= b;
        send_byte(b);
      end
      send_byte(nscc_pkg::CH_STAR);
      // Corrupt the checksum now and then.
      if ($urandom_range(0, 5) == 0) sum = 8'($urandom());
      case ($urandom_range(0, 9))
        0: ;
        1: send_byte(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
        default: begin
          send_byte(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
          send_byte(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
        end
      endcase
      if ($urandom_range(0, 4) == 0) send_byte(8'($urandom_range(32, 126)));
    end else begin
      // Broken lines start anyhow; noise lines may hold line feeds of their own.
      if (kind == 7) begin
        send_byte($urandom_range(0, 1) ? nscc_pkg::CH_DOLLAR : 8'($urandom()));
      end
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom());
        if (kind == 8 && b == nscc_pkg::CH_LF) b = nscc_pkg::CH_STAR;
        send_byte(b);
      end
    end
    send_byte(nscc_pkg::CH_LF);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  // Check every accepted verdict item.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) board.check_verdict(m_axis_tdata_o);
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d verdicts still queued.",
               cycle_cnt, board.outstanding());
      $display("** nmea_sentence_checksum_checker_core: FAILED **");
      $finish;
    end
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'd0;
    m_axis_tready_i = 1'b0;
    bytes_sent      = 0;
    cycle_cnt       = 0;
    stall_left      = 0;
    hold_left       = 0;
    hold_req        = 1'b0;
    no_idle         = 1'b0;
    board           = new();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed lines.
    // Empty line.
    send_byte(nscc_pkg::CH_LF);
    // Extremes of the byte, zero byte stopping the sum, mixed-case digits,
    // a byte after two digits ignored.
    send_byte(nscc_pkg::CH_DOLLAR);
    send_byte(8'hFF);
    send_byte(nscc_pkg::CH_NUL);
    send_byte(8'h01);
    send_text("*Ff7\n");
    // First byte is a star and must not count as the delimiter.
    send_text("**\n");
    // No delimiter at all.
    send_text("$a\n");
    // Sign after the delimiter stops the digits; an empty sum still matches.
    send_text("$*-5\n");
    // A second star ends the digits after one.
    send_text("$B*4*\n");

    // Random lines, with one long receiver hold-off and one full drain.
    while (bytes_sent < RANDOM_BYTES + 27) begin
      if (bytes_sent >= 180 && bytes_sent < 200) begin
        hold_req = 1'b1;
        no_idle  = 1'b1;
        repeat (12) send_byte(nscc_pkg::CH_LF);
        send_text("$GPGLL*27\n");
      end else if (bytes_sent >= 360 && bytes_sent < 380) begin
        // Stop offering while every queued verdict comes out.
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk_i);
        repeat (DRAIN_CYCLES) @(posedge clk_i);
        send_random_line();
      end else begin
        send_random_line();
      end
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    // Let the last verdicts drain.
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.outstanding() != 0) begin
      $error("%0d verdicts never arrived", board.outstanding());
      board.errors++;
    end

    $display("Sent %0d bytes; checked %0d verdicts, %0d valid and %0d with a delimiter.",
             bytes_sent, board.verdicts_seen, board.valid_lines, board.star_lines);
    if (board.errors == 0) begin
      $display("** nmea_sentence_checksum_checker_core: PASSED **");
    end else begin
      $display("** nmea_sentence_checksum_checker_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: nmea_sentence_checksum_checker_core.f
src/nscc_pkg.sv
src/nscc_line_tracker.sv
src/nscc_out_reg.sv
src/nmea_sentence_checksum_checker_core.sv
bench/nmea_sentence_checksum_checker_core_tb.sv
